/* rtl/fta_pkg.sv */
// Shared constants and types for the face track associator.
package fta_pkg;

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int LIMIT_W   = 8;
    localparam int OFF_W     = 15;

    localparam logic [CFG_IDX_W-1:0] REG_LOST_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_W    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_H    = 2'd3;

    localparam logic [LIMIT_W-1:0] RST_LOST_LIMIT = 8'd10;
    localparam logic [CFG_W-1:0]   RST_JUMP_THR   = 12'd50;
    localparam logic [CFG_W-1:0]   RST_FRAME_W    = 12'd640;
    localparam logic [CFG_W-1:0]   RST_FRAME_H    = 12'd480;

    // floor(n/7) = (n * DIV7_MUL) >> DIV7_SHIFT, exact for n below 2**16
    localparam int               DIV7_SHIFT = 19;
    localparam int               DIV7_MUL_W = 17;
    localparam logic [DIV7_MUL_W-1:0] DIV7_MUL = 17'd74899;

    localparam int OFF_MAX = 16383;
    localparam int OFF_MIN = -16384;

    typedef logic signed [OFF_W-1:0] t_offset;

endpackage

/* rtl/face_track_associator.sv */
// Face track associator: per frame, widest box if acquiring, else nearest gated.
//
// Input channel: one face box per transaction (i_valid / o_stall), or a box-less
// marker with i_has_face low. i_frame_end marks the last transaction of a frame.
// Output channel: one result per frame, on the frame-end transaction only
// (o_valid / i_stall): detect flag, held eye offset from frame centre in half
// pixels, held face width and the acquire flag after the frame.
// Configuration: plain write port (i_cfg_we, i_cfg_index, i_cfg_data); the user
// must write it only while the block is idle; the block does not enforce this.
// Flow: a transaction is registered on entry and its selection step is done
// from the input register; a frame result is registered in the result register
// when the frame-end transaction leaves the input register.
// Throughput: one transaction per cycle while o_stall is low, set by the compare
// and keep update of the best-candidate registers.
// Reset: acquire mode set, miss counter and held outputs cleared, registers take
// their default values (limit 10, threshold 50, frame 640 x 480).
// Stall: while a result waits, non-frame-end transactions still advance; a
// frame-end transaction waits in the input register, and o_stall rises only
// when that register cannot move.
module face_track_associator #(
    parameter int COORD_WIDTH = 12,
    parameter int MISS_WIDTH  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fta_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fta_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_has_face,
    input  logic [COORD_WIDTH-1:0]           i_box_x,
    input  logic [COORD_WIDTH-1:0]           i_box_y,
    input  logic [COORD_WIDTH-1:0]           i_box_w,
    input  logic [COORD_WIDTH-1:0]           i_box_h,
    input  logic                             i_frame_end,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_detected,
    output fta_pkg::t_offset                 o_offset_x_half,
    output fta_pkg::t_offset                 o_offset_y_half,
    output logic [COORD_WIDTH-1:0]           o_held_width,
    output logic                             o_acquiring
);

    localparam int C   = COORD_WIDTH;
    localparam int CW  = fta_pkg::CFG_W;
    localparam int MW  = (2*C+1 > 2*CW) ? 2*C+1 : 2*CW;
    localparam int NW  = (MISS_WIDTH+1 > fta_pkg::LIMIT_W) ? MISS_WIDTH+1 : fta_pkg::LIMIT_W;
    localparam int OW  = ((C > CW) ? C : CW) + 3;
    localparam int PW  = C + fta_pkg::DIV7_MUL_W;
    localparam int QW  = PW - fta_pkg::DIV7_SHIFT;
    localparam logic signed [OW-1:0] SAT_HI = OW'(fta_pkg::OFF_MAX);
    localparam logic signed [OW-1:0] SAT_LO = OW'(fta_pkg::OFF_MIN);
    localparam logic [MISS_WIDTH-1:0] MISS_TOP = '1;

    // configuration
    logic [fta_pkg::LIMIT_W-1:0] r_lost_limit;
    logic [CW-1:0]               r_frame_w;
    logic [CW-1:0]               r_frame_h;
    logic [2*CW-1:0]             r_thr_sq;
    logic [2*CW-1:0]             r_fw_sq;

    // input register
    logic          r_in_valid;
    logic          r_in_has;
    logic          r_in_fend;
    logic [C-1:0]  r_in_x;
    logic [C-1:0]  r_in_y;
    logic [C-1:0]  r_in_w;
    logic [C:0]    r_in_ex;
    logic [C:0]    r_in_ey;

    // tracking state
    logic                  r_acquire;
    logic [MISS_WIDTH-1:0] r_miss;
    logic [C-1:0]          r_last_x;
    logic [C-1:0]          r_last_y;
    logic                  r_saw;
    logic [MW-1:0]         r_metric;
    logic [C-1:0]          r_best_x;
    logic [C-1:0]          r_best_y;
    logic [C-1:0]          r_best_w;
    logic [C:0]            r_best_ex;
    logic [C:0]            r_best_ey;
    fta_pkg::t_offset      r_held_x;
    fta_pkg::t_offset      r_held_y;
    logic [C-1:0]          r_held_w;
    logic                  r_out_valid;
    logic                  r_out_detected;

    logic out_free;
    logic proc;
    logic in_free;
    logic in_take;

    assign out_free = !r_out_valid || !i_stall;
    assign proc     = r_in_valid && (!r_in_fend || out_free);
    assign in_free  = !r_in_valid || proc;
    assign in_take  = i_valid && in_free;
    assign o_stall  = !in_free;

    // eye point precompute on entry
    logic [PW-1:0] div7_prod;
    logic [QW-1:0] h_div7;
    logic [C:0]    in_ex;
    logic [C:0]    in_ey;

    always_comb begin
        div7_prod = PW'(i_box_h) * PW'(fta_pkg::DIV7_MUL);
        h_div7    = div7_prod[PW-1:fta_pkg::DIV7_SHIFT];
        in_ex     = (C+1)'(i_box_x) + (C+1)'(i_box_w[C-1:1]);
        in_ey     = (C+1)'(i_box_y) + (C+1)'(i_box_h[C-1:1]) - (C+1)'(h_div7);
    end

    // candidate selection
    logic [C-1:0]   dx;
    logic [C-1:0]   dy;
    logic [2*C-1:0] dx_sq;
    logic [2*C-1:0] dy_sq;
    logic [MW-1:0]  d_sq;
    logic [MW-1:0]  base_m;
    logic           n_saw;
    logic [MW-1:0]  n_metric;
    logic           load;

    always_comb begin
        dx     = (r_in_x >= r_last_x) ? r_in_x - r_last_x : r_last_x - r_in_x;
        dy     = (r_in_y >= r_last_y) ? r_in_y - r_last_y : r_last_y - r_in_y;
        dx_sq  = (2*C)'(dx) * (2*C)'(dx);
        dy_sq  = (2*C)'(dy) * (2*C)'(dy);
        d_sq   = MW'(dx_sq) + MW'(dy_sq);
        base_m = r_saw ? r_metric : MW'(r_fw_sq);
        n_saw    = r_saw;
        n_metric = r_metric;
        load     = 1'b0;
        if (r_in_has) begin
            n_saw = 1'b1;
            if (r_acquire) begin
                if (!r_saw || MW'(r_in_w) > r_metric) begin
                    load     = 1'b1;
                    n_metric = MW'(r_in_w);
                end
            end else begin
                n_metric = (d_sq < base_m) ? d_sq : base_m;
                load     = !r_saw || (d_sq < base_m);
            end
        end
    end

    logic [C-1:0] n_best_x;
    logic [C-1:0] n_best_y;
    logic [C-1:0] n_best_w;
    logic [C:0]   n_best_ex;
    logic [C:0]   n_best_ey;

    always_comb begin
        n_best_x  = load ? r_in_x  : r_best_x;
        n_best_y  = load ? r_in_y  : r_best_y;
        n_best_w  = load ? r_in_w  : r_best_w;
        n_best_ex = load ? r_in_ex : r_best_ex;
        n_best_ey = load ? r_in_ey : r_best_ey;
    end

    // frame close
    logic                  accept;
    logic [NW-1:0]         miss_next;
    logic                  n_acquire;
    logic [MISS_WIDTH-1:0] n_miss;
    logic signed [OW-1:0]  off_x;
    logic signed [OW-1:0]  off_y;
    fta_pkg::t_offset      sat_x;
    fta_pkg::t_offset      sat_y;

    always_comb begin
        if (r_acquire) begin
            accept = n_saw;
        end else begin
            accept = n_saw && (n_metric <= MW'(r_thr_sq));
        end
        miss_next = NW'(r_miss) + NW'(1);
        n_acquire = r_acquire;
        n_miss    = r_miss;
        if (accept) begin
            n_acquire = 1'b0;
        end else if (miss_next > NW'(r_lost_limit)) begin
            n_acquire = 1'b1;
            n_miss    = '0;
        end else if (miss_next > NW'(MISS_TOP)) begin
            n_miss = MISS_TOP;
        end else begin
            n_miss = miss_next[MISS_WIDTH-1:0];
        end
        off_x = $signed(OW'(r_frame_w)) - $signed(OW'({n_best_ex, 1'b0}));
        off_y = $signed(OW'(r_frame_h)) - $signed(OW'({n_best_ey, 1'b0}));
        priority if (off_x > SAT_HI) begin
            sat_x = fta_pkg::t_offset'(SAT_HI);
        end else if (off_x < SAT_LO) begin
            sat_x = fta_pkg::t_offset'(SAT_LO);
        end else begin
            sat_x = fta_pkg::t_offset'(off_x);
        end
        priority if (off_y > SAT_HI) begin
            sat_y = fta_pkg::t_offset'(SAT_HI);
        end else if (off_y < SAT_LO) begin
            sat_y = fta_pkg::t_offset'(SAT_LO);
        end else begin
            sat_y = fta_pkg::t_offset'(off_y);
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lost_limit <= fta_pkg::RST_LOST_LIMIT;
            r_frame_w    <= fta_pkg::RST_FRAME_W;
            r_frame_h    <= fta_pkg::RST_FRAME_H;
            r_thr_sq     <= (2*CW)'(fta_pkg::RST_JUMP_THR) * (2*CW)'(fta_pkg::RST_JUMP_THR);
            r_fw_sq      <= (2*CW)'(fta_pkg::RST_FRAME_W) * (2*CW)'(fta_pkg::RST_FRAME_W);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fta_pkg::REG_LOST_LIMIT: begin
                    r_lost_limit <= i_cfg_data[fta_pkg::LIMIT_W-1:0];
                end
                fta_pkg::REG_JUMP_THR: begin
                    r_thr_sq <= (2*CW)'(i_cfg_data) * (2*CW)'(i_cfg_data);
                end
                fta_pkg::REG_FRAME_W: begin
                    r_frame_w <= i_cfg_data;
                    r_fw_sq   <= (2*CW)'(i_cfg_data) * (2*CW)'(i_cfg_data);
                end
                fta_pkg::REG_FRAME_H: begin
                    r_frame_h <= i_cfg_data;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_has  <= i_has_face;
            r_in_fend <= i_frame_end;
            r_in_x    <= i_box_x;
            r_in_y    <= i_box_y;
            r_in_w    <= i_box_w;
            r_in_ex   <= in_ex;
            r_in_ey   <= in_ey;
        end
    end

    // tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acquire <= 1'b1;
            r_miss    <= '0;
            r_last_x  <= '0;
            r_last_y  <= '0;
            r_saw     <= 1'b0;
            r_held_x  <= '0;
            r_held_y  <= '0;
            r_held_w  <= '0;
        end else if (proc) begin
            if (r_in_fend) begin
                r_saw     <= 1'b0;
                r_acquire <= n_acquire;
                r_miss    <= n_miss;
                if (accept) begin
                    r_last_x <= n_best_x;
                    r_last_y <= n_best_y;
                    r_held_x <= sat_x;
                    r_held_y <= sat_y;
                    r_held_w <= n_best_w;
                end
            end else begin
                r_saw <= n_saw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_metric  <= n_metric;
            r_best_x  <= n_best_x;
            r_best_y  <= n_best_y;
            r_best_w  <= n_best_w;
            r_best_ex <= n_best_ex;
            r_best_ey <= n_best_ey;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc && r_in_fend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_fend) begin
            r_out_detected <= accept;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_detected      = r_out_detected;
    assign o_offset_x_half = r_held_x;
    assign o_offset_y_half = r_held_y;
    assign o_held_width    = r_held_w;
    assign o_acquiring     = r_acquire;

    a_detect_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_detected) |-> !r_acquire)
        else $error("detected result reported while still acquiring");

    a_frame_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_fend) |=> (!r_saw && r_out_valid))
        else $error("frame close did not clear candidate or raise result");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(proc && r_in_fend))
        else $error("result appeared without a frame-end transaction");

    a_fend_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_fend && r_out_valid && i_stall) |=> r_in_valid)
        else $error("frame-end transaction dropped while result stalled");

endmodule

/* bench/face_track_associator_test.sv */
// Self-checking bench for face_track_associator: frame stimulus, reference predictor, result checks.
`timescale 1ns / 1ps

module face_track_associator_test;

    localparam int CW = 12;

    typedef struct packed {
        logic          has_face;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] w;
        logic [CW-1:0] h;
        logic          frame_end;
    } t_box_item;

    typedef struct packed {
        logic             detected;
        fta_pkg::t_offset off_x;
        fta_pkg::t_offset off_y;
        logic [CW-1:0]    width;
        logic             acquiring;
    } t_frame_report;

    class t_track_checker;
        logic [fta_pkg::LIMIT_W-1:0] lost_limit;
        logic [CW-1:0]               jump_thr;
        logic [CW-1:0]               frame_w;
        logic [CW-1:0]               frame_h;
        logic                        acquire;
        int unsigned                 misses;
        logic [CW-1:0]               track_x;
        logic [CW-1:0]               track_y;
        longint unsigned             best_metric;
        t_box_item                   best;
        logic                        saw_box;
        fta_pkg::t_offset            hold_x;
        fta_pkg::t_offset            hold_y;
        logic [CW-1:0]               hold_w;
        t_frame_report               reports_due[$];
        int                          errors;

        function new();
            lost_limit  = fta_pkg::RST_LOST_LIMIT;
            jump_thr    = fta_pkg::RST_JUMP_THR;
            frame_w     = fta_pkg::RST_FRAME_W;
            frame_h     = fta_pkg::RST_FRAME_H;
            acquire     = 1'b1;
            misses      = 0;
            track_x     = '0;
            track_y     = '0;
            best_metric = 0;
            best        = '0;
            saw_box     = 1'b0;
            hold_x      = '0;
            hold_y      = '0;
            hold_w      = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [fta_pkg::CFG_IDX_W-1:0] index,
                                logic [fta_pkg::CFG_W-1:0] data);
            case (index)
                fta_pkg::REG_LOST_LIMIT: lost_limit = data[fta_pkg::LIMIT_W-1:0];
                fta_pkg::REG_JUMP_THR:   jump_thr   = data;
                fta_pkg::REG_FRAME_W:    frame_w    = data;
                fta_pkg::REG_FRAME_H:    frame_h    = data;
                default: ;
            endcase
        endfunction

        function longint unsigned sq_diff(logic [CW-1:0] a, logic [CW-1:0] b);
            longint unsigned d;
            d = (a > b) ? longint'(a - b) : longint'(b - a);
            return d * d;
        endfunction

        function fta_pkg::t_offset clamp_offset(longint v);
            if (v > fta_pkg::OFF_MAX) return fta_pkg::t_offset'(fta_pkg::OFF_MAX);
            if (v < fta_pkg::OFF_MIN) return fta_pkg::t_offset'(fta_pkg::OFF_MIN);
            return fta_pkg::t_offset'(v);
        endfunction

        function void take_box(t_box_item it);
            longint unsigned d;
            longint unsigned fw;
            longint unsigned thr;
            longint          ex;
            longint          ey;
            logic            accept;
            int unsigned     next;
            t_frame_report   r;
            fw  = frame_w;
            thr = jump_thr;
            if (it.has_face) begin
                if (acquire) begin
                    if (!saw_box || longint'(it.w) > best_metric) begin
                        best_metric = it.w;
                        best = it;
                    end
                end else begin
                    d = sq_diff(it.x, track_x) + sq_diff(it.y, track_y);
                    if (!saw_box) begin
                        best_metric = fw * fw;
                        best = it;
                    end
                    if (d < best_metric) begin
                        best_metric = d;
                        best = it;
                    end
                end
                saw_box = 1'b1;
            end
            if (!it.frame_end) return;
            accept = 1'b0;
            if (saw_box) begin
                if (acquire) begin
                    accept  = 1'b1;
                    acquire = 1'b0;
                end else begin
                    accept = (best_metric <= thr * thr);
                end
            end
            if (accept) begin
                ex = longint'(best.x) + longint'(best.w / 2);
                ey = longint'(best.y) + longint'(best.h / 2) - longint'(best.h / 7);
                track_x = best.x;
                track_y = best.y;
                hold_x  = clamp_offset(longint'(frame_w) - 2 * ex);
                hold_y  = clamp_offset(longint'(frame_h) - 2 * ey);
                hold_w  = best.w;
            end else begin
                next = misses + 1;
                if (next > lost_limit) begin
                    acquire = 1'b1;
                    misses  = 0;
                end else begin
                    misses = (next > 255) ? 255 : next;
                end
            end
            saw_box     = 1'b0;
            best_metric = 0;
            best        = '0;
            r.detected  = accept;
            r.off_x     = hold_x;
            r.off_y     = hold_y;
            r.width     = hold_w;
            r.acquiring = acquire;
            reports_due.push_back(r);
        endfunction

        function void check_report(t_frame_report got);
            t_frame_report want;
            if (reports_due.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            want = reports_due.pop_front();
            if (got.detected !== want.detected) begin
                $error("detected: expected %0d, actual %0d", want.detected, got.detected);
                errors++;
            end
            if (got.off_x !== want.off_x) begin
                $error("offset_x_half: expected %0d, actual %0d", want.off_x, got.off_x);
                errors++;
            end
            if (got.off_y !== want.off_y) begin
                $error("offset_y_half: expected %0d, actual %0d", want.off_y, got.off_y);
                errors++;
            end
            if (got.width !== want.width) begin
                $error("held_width: expected %0d, actual %0d", want.width, got.width);
                errors++;
            end
            if (got.acquiring !== want.acquiring) begin
                $error("acquiring: expected %0d, actual %0d", want.acquiring, got.acquiring);
                errors++;
            end
        endfunction

        function int due();
            return reports_due.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [fta_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [fta_pkg::CFG_W-1:0]     i_cfg_data;
    logic                          i_valid;
    logic                          o_stall;
    logic                          i_has_face;
    logic [CW-1:0]                 i_box_x;
    logic [CW-1:0]                 i_box_y;
    logic [CW-1:0]                 i_box_w;
    logic [CW-1:0]                 i_box_h;
    logic                          i_frame_end;
    logic                          o_valid;
    logic                          i_stall;
    logic                          o_detected;
    fta_pkg::t_offset              o_offset_x_half;
    fta_pkg::t_offset              o_offset_y_half;
    logic [CW-1:0]                 o_held_width;
    logic                          o_acquiring;

    face_track_associator #(
        .COORD_WIDTH(CW),
        .MISS_WIDTH (8)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_has_face     (i_has_face),
        .i_box_x        (i_box_x),
        .i_box_y        (i_box_y),
        .i_box_w        (i_box_w),
        .i_box_h        (i_box_h),
        .i_frame_end    (i_frame_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_detected     (o_detected),
        .o_offset_x_half(o_offset_x_half),
        .o_offset_y_half(o_offset_y_half),
        .o_held_width   (o_held_width),
        .o_acquiring    (o_acquiring)
    );

    t_track_checker tracker = new();
    int             items_sent = 0;
    int             gap_pct = 0;
    int             stall_pct = 0;
    logic           quiet = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL face_track_associator");
        $finish;
    end

    initial begin : result_monitor
        int hold;
        t_frame_report got;
        hold = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.detected  = o_detected;
                got.off_x     = o_offset_x_half;
                got.off_y     = o_offset_y_half;
                got.width     = o_held_width;
                got.acquiring = o_acquiring;
                tracker.check_report(got);
            end
            if (hold > 0) begin
                hold--;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                hold = $urandom_range(1, 10);
            end
            i_stall <= (hold > 0);
        end
    end

    function automatic t_box_item make_box(logic has, int x, int y, int w, int h, logic fend);
        t_box_item it;
        it.has_face  = has;
        it.x         = CW'(x);
        it.y         = CW'(y);
        it.w         = CW'(w);
        it.h         = CW'(h);
        it.frame_end = fend;
        return it;
    endfunction

    function automatic logic [CW-1:0] near_coord(logic [CW-1:0] base, int span);
        int v;
        v = int'(base) + $urandom_range(0, 2 * span) - span;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return CW'(v);
    endfunction

    task automatic send_box(input t_box_item it);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_has_face  <= it.has_face;
        i_box_x     <= it.x;
        i_box_y     <= it.y;
        i_box_w     <= it.w;
        i_box_h     <= it.h;
        i_frame_end <= it.frame_end;
        do @(posedge i_clk); while (o_stall);
        tracker.take_box(it);
        items_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (tracker.due() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_regs(input int limit, input int thr, input int fw, input int fh);
        logic [fta_pkg::CFG_W-1:0]     data [4];
        logic [fta_pkg::CFG_IDX_W-1:0] idx [4];
        data[0] = {4'($urandom), 8'(limit)};
        data[1] = fta_pkg::CFG_W'(thr);
        data[2] = fta_pkg::CFG_W'(fw);
        data[3] = fta_pkg::CFG_W'(fh);
        idx[0]  = fta_pkg::REG_LOST_LIMIT;
        idx[1]  = fta_pkg::REG_JUMP_THR;
        idx[2]  = fta_pkg::REG_FRAME_W;
        idx[3]  = fta_pkg::REG_FRAME_H;
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= data[k];
            @(posedge i_clk);
            tracker.write_reg(idx[k], data[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_frame();
        int        kind;
        int        n;
        int        span;
        logic      tail_marker;
        t_box_item it;
        kind = $urandom_range(0, 99);
        span = int'(tracker.jump_thr) * 7 / 10 + 1;
        if (kind < 12) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
                it = t_box_item'({$urandom, $urandom});
                it.has_face  = 1'b0;
                it.frame_end = (k == n - 1);
                send_box(it);
            end
        end else if (kind < 25) begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
                it = t_box_item'({$urandom, $urandom});
                it.frame_end = (k == n - 1);
                send_box(it);
            end
        end else begin
            n = $urandom_range(1, 5);
            tail_marker = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    it = t_box_item'({$urandom, $urandom});
                    it.has_face  = 1'b0;
                    it.frame_end = 1'b0;
                    send_box(it);
                end
                it = t_box_item'({$urandom, $urandom});
                it.has_face = 1'b1;
                if ($urandom_range(0, 9) < 6) begin
                    it.x = near_coord(tracker.track_x, span);
                    it.y = near_coord(tracker.track_y, span);
                end
                if ($urandom_range(0, 7) == 0) begin
                    it.x = near_coord(tracker.track_x, 0);
                    it.y = near_coord(tracker.track_y, 0);
                end
                if ($urandom_range(0, 3) == 0) it.w = CW'(200);
                it.frame_end = (k == n - 1) && !tail_marker;
                send_box(it);
            end
            if (tail_marker) begin
                it = t_box_item'({$urandom, $urandom});
                it.has_face  = 1'b0;
                it.frame_end = 1'b1;
                send_box(it);
            end
        end
    endtask

    initial begin : stimulus
        int target;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= fta_pkg::REG_LOST_LIMIT;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_has_face  <= 1'b0;
        i_box_x     <= '0;
        i_box_y     <= '0;
        i_box_w     <= '0;
        i_box_h     <= '0;
        i_frame_end <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_box(make_box(1'b0, 4095, 4095, 4095, 4095, 1'b1));
        send_box(make_box(1'b1, 0, 0, 0, 0, 1'b0));
        send_box(make_box(1'b1, 4095, 4095, 4095, 4095, 1'b0));
        send_box(make_box(1'b1, 10, 20, 4095, 4095, 1'b0));
        send_box(make_box(1'b0, 4095, 4095, 4095, 4095, 1'b1));
        send_box(make_box(1'b1, 4065, 4055, 64, 70, 1'b1));
        send_box(make_box(1'b1, 0, 0, 33, 44, 1'b1));
        send_box(make_box(1'b1, 4014, 4055, 50, 60, 1'b0));
        send_box(make_box(1'b0, 0, 0, 0, 0, 1'b0));
        send_box(make_box(1'b1, 4065, 4045, 90, 99, 1'b1));
        send_box(make_box(1'b1, 4065, 3994, 90, 99, 1'b1));
        send_box(make_box(1'b0, 0, 0, 0, 0, 1'b1));
        send_box(make_box(1'b1, 4065, 4045, 1, 6, 1'b1));
        settle();
        write_regs(0, 0, 1, 1);
        send_box(make_box(1'b0, 0, 0, 0, 0, 1'b1));
        send_box(make_box(1'b1, 100, 100, 7, 7, 1'b1));
        send_box(make_box(1'b1, 100, 100, 8, 14, 1'b1));
        send_box(make_box(1'b1, 101, 100, 8, 14, 1'b1));
        send_box(make_box(1'b1, 5, 5, 5, 5, 1'b1));
        settle();
        write_regs(255, 4095, 4095, 4095);
        send_box(make_box(1'b1, 0, 0, 4095, 4095, 1'b1));
        send_box(make_box(1'b1, 4095, 4095, 0, 0, 1'b1));
        send_box(make_box(1'b1, 0, 4095, 12, 12, 1'b1));

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0: write_regs(0, 0, 1, 1);
                1: write_regs(255, 4095, 4095, 4095);
                2: write_regs(fta_pkg::RST_LOST_LIMIT, fta_pkg::RST_JUMP_THR,
                              fta_pkg::RST_FRAME_W, fta_pkg::RST_FRAME_H);
                default: write_regs(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                                : $urandom_range(0, 12),
                                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                                : $urandom_range(0, 300),
                                    $urandom_range(1, 4095), $urandom_range(1, 4095));
            endcase
            quiet     = (ph == 7);
            gap_pct   = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 10 : 30);
            stall_pct = (ph % 4 == 1) ? 0 : ((ph % 2 == 0) ? 15 : 35);
            target    = 22 + (ph + 1) * 192;
            while (items_sent < target) send_random_frame();
        end
        settle();
        if (tracker.errors == 0) begin
            $display("PASS face_track_associator");
        end else begin
            $display("FAIL face_track_associator");
        end
        $finish;
    end

endmodule

/* face_track_associator.f */
rtl/fta_pkg.sv
rtl/face_track_associator.sv
bench/face_track_associator_test.sv
